// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the timestamp converter.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/ists_pkg.sv -----
// Types, constants and helper functions for the timestamp converter.
// No dependencies; used by ists_ctrl, ists_datapath and the top level.
`timescale 1ns / 1ps

package ists_pkg;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // String positions
    localparam logic [4:0] POS_LIMIT = 5'd19;  // length that enables the time part
    localparam logic [4:0] LEN_DATE  = 5'd10;  // shortest valid string

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } ists_char_t;

    typedef struct packed {
        logic signed [38:0] unix_seconds;
        logic               valid_res;
    } ists_result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take_char;   // accumulate the accepted character
        logic start;       // latch checks and operands, clear the parser
        logic step_era;    // era and year of era
        logic step_doe;    // day of era
        logic step_days;   // days since epoch
        logic step_secs;   // seconds since epoch
        logic load_out;    // load the result register
    } ists_cmd_t;

    // floor(t / 25) for t up to 624, by reciprocal multiply
    function automatic logic [4:0] div25(input logic [9:0] t);
        logic [21:0] p;
        p = t * 22'd2622;
        return 5'(p >> 16);
    endfunction

    // Days before the first of a March-based month: (153 * mp + 2) / 5
    function automatic logic [8:0] month_days(input logic [3:0] mp);
        logic [8:0] d;
        unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/core/ists_ctrl.sv -----
// Controller of the timestamp converter: handshakes and step sequencing.
// Depends on ists_pkg.
`timescale 1ns / 1ps

module ists_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    input  logic              char_last,
    output logic              char_ready,
    output logic              result_valid,
    input  logic              result_ready,
    output ists_pkg::ists_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_RUN,
        ST_C1,
        ST_C2,
        ST_C3,
        ST_C4,
        ST_C5,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   char_ready_reg;
    logic   result_valid_reg;
    logic   take;
    logic   load;

    assign take = char_ready_reg && char_valid;
    assign load = (state_reg == ST_DONE) && (!result_valid_reg || result_ready);

    always_comb
    begin
        cmd           = '0;
        cmd.take_char = take;
        cmd.start     = (state_reg == ST_C1);
        cmd.step_era  = (state_reg == ST_C2);
        cmd.step_doe  = (state_reg == ST_C3);
        cmd.step_days = (state_reg == ST_C4);
        cmd.step_secs = (state_reg == ST_C5);
        cmd.load_out  = load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_RUN;
            char_ready_reg   <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // a load in the same cycle as the handover keeps valid high
            priority if (load)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && result_ready)
                result_valid_reg <= 1'b0;
            else
                result_valid_reg <= result_valid_reg;
            unique case (state_reg)
                ST_RUN:
                begin
                    if (take && char_last)
                    begin
                        state_reg      <= ST_C1;
                        char_ready_reg <= 1'b0;
                    end
                end
                ST_C1: state_reg <= ST_C2;
                ST_C2: state_reg <= ST_C3;
                ST_C3: state_reg <= ST_C4;
                ST_C4: state_reg <= ST_C5;
                ST_C5: state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (load)
                    begin
                        state_reg      <= ST_RUN;
                        char_ready_reg <= 1'b1;
                    end
                end
                default: state_reg <= ST_RUN;
            endcase
        end
    end

    assign char_ready   = char_ready_reg;
    assign result_valid = result_valid_reg;

endmodule

// ----- rtl/core/ists_datapath.sv -----
// Datapath of the timestamp converter: character parser, days-from-civil
// steps and the result register. Depends on ists_pkg.
`timescale 1ns / 1ps

module ists_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ists_pkg::ists_cmd_t    cmd,
    input  ists_pkg::ists_char_t   char_item,
    output ists_pkg::ists_result_t result_item
);

    // Parser state
    logic [4:0]  pos_reg, pos_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic        date_ok_reg, date_ok_next;
    logic        time_ok_reg, time_ok_next;
    logic        time_sep_reg, time_sep_next;

    logic [7:0]  c;
    logic        is_digit;
    logic [3:0]  digit;

    // Arithmetic registers
    logic               ok_reg;
    logic signed [14:0] yy_reg;
    logic [3:0]         mp_reg;
    logic [4:0]         dd_reg;
    logic [16:0]        tod_reg;
    logic signed [5:0]  era_reg;
    logic [8:0]         yoe_reg;
    logic [17:0]        doe_reg;
    logic signed [22:0] days_reg;
    logic signed [38:0] secs_reg;
    ists_pkg::ists_result_t result_reg;

    assign c        = char_item.char_code;
    assign is_digit = (c >= ists_pkg::CH_ZERO) && (c <= ists_pkg::CH_NINE);
    assign digit    = 4'(c - ists_pkg::CH_ZERO);

    always_comb
    begin
        pos_next      = pos_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        date_ok_next  = date_ok_reg;
        time_ok_next  = time_ok_reg;
        time_sep_next = time_sep_reg;
        if (cmd.start)
        begin
            pos_next      = '0;
            year_next     = '0;
            month_next    = '0;
            day_next      = '0;
            hour_next     = '0;
            minute_next   = '0;
            second_next   = '0;
            date_ok_next  = 1'b1;
            time_ok_next  = 1'b1;
            time_sep_next = 1'b0;
        end
        else if (cmd.take_char)
        begin
            unique case (pos_reg)
                5'd0, 5'd1, 5'd2, 5'd3:
                    if (is_digit) year_next = year_reg * 14'd10 + 14'(digit);
                    else          date_ok_next = 1'b0;
                5'd4, 5'd7:
                    if (c != ists_pkg::CH_DASH) date_ok_next = 1'b0;
                5'd5, 5'd6:
                    if (is_digit) month_next = month_reg * 7'd10 + 7'(digit);
                    else          date_ok_next = 1'b0;
                5'd8, 5'd9:
                    if (is_digit) day_next = day_reg * 7'd10 + 7'(digit);
                    else          date_ok_next = 1'b0;
                5'd10:
                    time_sep_next = (c == ists_pkg::CH_T) || (c == ists_pkg::CH_SPACE);
                5'd11, 5'd12:
                    if (is_digit) hour_next = hour_reg * 7'd10 + 7'(digit);
                    else          time_ok_next = 1'b0;
                5'd13, 5'd16:
                    if (c != ists_pkg::CH_COLON) time_ok_next = 1'b0;
                5'd14, 5'd15:
                    if (is_digit) minute_next = minute_reg * 7'd10 + 7'(digit);
                    else          time_ok_next = 1'b0;
                5'd17, 5'd18:
                    if (is_digit) second_next = second_reg * 7'd10 + 7'(digit);
                    else          time_ok_next = 1'b0;
                default: ;
            endcase
            if (pos_reg < ists_pkg::POS_LIMIT)
                pos_next = pos_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            year_reg     <= '0;
            month_reg    <= '0;
            day_reg      <= '0;
            hour_reg     <= '0;
            minute_reg   <= '0;
            second_reg   <= '0;
            date_ok_reg  <= 1'b1;
            time_ok_reg  <= 1'b1;
            time_sep_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            year_reg     <= year_next;
            month_reg    <= month_next;
            day_reg      <= day_next;
            hour_reg     <= hour_next;
            minute_reg   <= minute_next;
            second_reg   <= second_next;
            date_ok_reg  <= date_ok_next;
            time_ok_reg  <= time_ok_next;
            time_sep_reg <= time_sep_next;
        end
    end

    // Step 1: range checks, shifted year and month, time of day
    logic               use_time;
    logic [6:0]         h, mi, s;
    logic               ok_c;
    logic signed [14:0] yy_c;
    logic [3:0]         mp_c;
    logic [16:0]        tod_c;

    always_comb
    begin
        use_time = (pos_reg == ists_pkg::POS_LIMIT) && time_sep_reg;
        h  = use_time ? hour_reg   : 7'd0;
        mi = use_time ? minute_reg : 7'd0;
        s  = use_time ? second_reg : 7'd0;
        ok_c = (pos_reg >= ists_pkg::LEN_DATE) && date_ok_reg
            && (!use_time || time_ok_reg)
            && (month_reg >= 7'd1) && (month_reg <= 7'd12)
            && (day_reg >= 7'd1) && (day_reg <= 7'd31)
            && (h <= 7'd23) && (mi <= 7'd59) && (s <= 7'd60);
        yy_c  = $signed({1'b0, year_reg}) - ((month_reg <= 7'd2) ? 15'sd1 : 15'sd0);
        mp_c  = (month_reg > 7'd2) ? 4'(month_reg - 7'd3) : 4'(month_reg + 7'd9);
        tod_c = h * 17'd3600 + mi * 17'd60 + 17'(s);
    end

    // Step 2: era = floor(yy / 400), year of era
    logic signed [5:0]  era_c;
    logic signed [14:0] yoe_c;

    always_comb
    begin
        if (yy_reg[14])
            era_c = -6'sd1;
        else
            era_c = $signed({1'b0, ists_pkg::div25(yy_reg[13:4])});
        yoe_c = yy_reg - era_c * 15'sd400;
    end

    // Step 3: day of era
    logic [6:0]  q4;
    logic [4:0]  c100;
    logic [17:0] doe_c;

    always_comb
    begin
        q4    = yoe_reg[8:2];
        c100  = ists_pkg::div25({3'b000, q4});
        doe_c = yoe_reg * 18'd365 + 18'(q4) - 18'(c100)
              + 18'(ists_pkg::month_days(mp_reg)) + 18'(dd_reg) - 18'd1;
    end

    // Step 4 and 5: days, then seconds
    logic signed [23:0] days_c;
    logic signed [39:0] secs_c;

    always_comb
    begin
        days_c = 24'(era_reg) * 24'sd146097 + $signed({6'b0, doe_reg}) - 24'sd719468;
        secs_c = 40'(days_reg) * 40'sd86400 + $signed({23'b0, tod_reg});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            ok_reg  <= ok_c;
            yy_reg  <= yy_c;
            mp_reg  <= mp_c;
            dd_reg  <= day_reg[4:0];
            tod_reg <= tod_c;
        end
        if (cmd.step_era)
        begin
            era_reg <= era_c;
            yoe_reg <= yoe_c[8:0];
        end
        if (cmd.step_doe)
            doe_reg <= doe_c;
        if (cmd.step_days)
            days_reg <= days_c[22:0];
        if (cmd.step_secs)
            secs_reg <= secs_c[38:0];
        if (cmd.load_out)
        begin
            result_reg.unix_seconds <= ok_reg ? secs_reg : '0;
            result_reg.valid_res    <= ok_reg;
        end
    end

    assign result_item = result_reg;

endmodule

// ----- rtl/core/iso8601_to_unix_seconds_top.sv -----
// Top level of the ISO-8601 timestamp to Unix seconds converter.
// Depends on ists_pkg, ists_ctrl, ists_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   Char channel (char_valid / char_ready / char_item): one string character
//   per transaction, char_item.last_char set on the final one. The form taken
//   is YYYY-MM-DD, optionally followed by T or space and HH:MM:SS; anything
//   past the nineteenth character is ignored.
//   Result channel (result_valid / result_ready / result_item): one
//   transaction per string, carrying proleptic Gregorian seconds since
//   1970-01-01T00:00:00 and valid_res; unix_seconds is zero when not valid.
// Timing
//   Characters go in at one per cycle while char_ready is high. After the
//   last-character transaction the controller runs five arithmetic steps and
//   a load, and the char channel is not ready until that load is done; the
//   load waits while the output register holds a result not yet taken.
// Reset
//   rst_n clears the parser, the controller and result_valid; char_ready is
//   high right after reset.
// Stall
//   The result sits in an output register; the next string is taken in while
//   it waits, and a second result holds in the last step until it frees up.

module iso8601_to_unix_seconds_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_ready,
    input  ists_pkg::ists_char_t   char_item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output ists_pkg::ists_result_t result_item
);

    ists_pkg::ists_cmd_t cmd;

    // Handshakes and step sequencing
    ists_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_last    (char_item.last_char),
        .char_ready   (char_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    // Parser, date arithmetic and result register
    ists_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .char_item   (char_item),
        .result_item (result_item)
    );

    // The last character closes the char channel while the arithmetic runs
    `ASSERT_NEXT(a_last_blocks, clk, rst_n, char_valid && char_ready && char_item.last_char, !char_ready, "char channel open after last character")

    // An invalid result always carries zero seconds
    `ASSERT_IMPL(a_invalid_zero, clk, rst_n, result_valid, result_item.valid_res || (result_item.unix_seconds == '0), "invalid result with nonzero seconds")

    // A new result only appears out of the load step, never while parsing
    `ASSERT_IMPL(a_load_step, clk, rst_n, $rose(result_valid), $past(!char_ready), "result appeared while parsing")

endmodule
